FILE: design/rfhft_pkg.sv
package rfhft_pkg;

	localparam int unsigned FRAME_CHARS_DEF = 128;

	localparam logic [7:0]  BYTE_START    = 8'h02;
	localparam logic [7:0]  BYTE_END      = 8'h03;
	localparam logic [31:0] TIMEOUT_RESET = 32'd200000;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic EVENT_NEW  = 1'b0;
	localparam logic EVENT_LOST = 1'b1;

	typedef enum logic [2:0] {
		KIND_TICK,
		KIND_START,
		KIND_END,
		KIND_HEX,
		KIND_OTHER
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [3:0] digit;
	} item_t;

	typedef struct packed {
		logic        event_res;
		logic [63:0] tag_serial;
	} result_t;

endpackage

FILE: design/rfhft_fifo.sv
module rfhft_fifo #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

FILE: design/rfhft_front.sv
module rfhft_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic            command,
	input  logic [7:0]      rx_byte,
	input  logic            item_take,
	output rfhft_pkg::item_t item,
	output logic            item_empty
);
	import rfhft_pkg::*;

	item_t cls;

	always_comb begin
		cls.kind  = KIND_OTHER;
		cls.digit = 4'd0;
		if (command == CMD_TICK) begin
			cls.kind = KIND_TICK;
		end else if (rx_byte == BYTE_START) begin
			cls.kind = KIND_START;
		end else if (rx_byte == BYTE_END) begin
			cls.kind = KIND_END;
		end else if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
			cls.kind  = KIND_HEX;
			cls.digit = rx_byte[3:0];
		end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
		             (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
			cls.kind  = KIND_HEX;
			cls.digit = rx_byte[3:0] + 4'd9;
		end
	end

	logic [$bits(item_t)-1:0] q_dout;

	rfhft_fifo #(
		.W($bits(item_t))
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cls),
		.full  (full),
		.pop   (item_take),
		.dout  (q_dout),
		.empty (item_empty)
	);

	assign item = item_t'(q_dout);

endmodule

FILE: design/rfhft_back.sv
module rfhft_back #(
	parameter int unsigned MAX_FRAME_CHARS = rfhft_pkg::FRAME_CHARS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data,
	input  rfhft_pkg::item_t item,
	input  logic             item_empty,
	output logic             item_take,
	output logic             empty,
	input  logic             pop,
	output logic             event_res,
	output logic [63:0]      tag_serial
);
	import rfhft_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FRAME_CHARS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_CHARS);

	logic [31:0]   timeout_q;
	logic          in_frame_q;
	logic [CW-1:0] char_count_q;
	logic [63:0]   hex_accum_q;
	logic          stopped_q;
	logic          overflow_q;
	logic [63:0]   held_tag_q;
	logic [31:0]   elapsed_q;

	logic        res_full;
	logic        res_push;
	result_t     res;
	logic [31:0] elapsed_inc;
	logic [63:0] frame_value;
	logic        lost_hit;

	assign item_take   = !item_empty && !res_full;
	assign elapsed_inc = (elapsed_q == 32'hFFFF_FFFF) ? elapsed_q : elapsed_q + 32'd1;
	assign lost_hit    = (held_tag_q != 64'd0) && (elapsed_inc > timeout_q);
	assign frame_value = overflow_q ? 64'hFFFF_FFFF_FFFF_FFFF : hex_accum_q;

	always_comb begin
		res_push       = 1'b0;
		res.event_res  = EVENT_NEW;
		res.tag_serial = frame_value;
		if (item_take) begin
			unique case (item.kind)
				KIND_TICK: begin
					res.event_res  = EVENT_LOST;
					res.tag_serial = held_tag_q;
					res_push       = lost_hit;
				end
				KIND_END: begin
					res_push = in_frame_q && (frame_value != held_tag_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			char_count_q <= '0;
			hex_accum_q  <= 64'd0;
			stopped_q    <= 1'b0;
			overflow_q   <= 1'b0;
			held_tag_q   <= 64'd0;
			elapsed_q    <= 32'd0;
		end else if (item_take) begin
			if (item.kind == KIND_TICK) begin
				elapsed_q <= elapsed_inc;
				if (lost_hit) begin
					held_tag_q <= 64'd0;
				end
			end else if (!in_frame_q) begin
				if (item.kind == KIND_START) begin
					in_frame_q   <= 1'b1;
					char_count_q <= '0;
					hex_accum_q  <= 64'd0;
					stopped_q    <= 1'b0;
					overflow_q   <= 1'b0;
				end
			end else if (item.kind == KIND_END) begin
				if (frame_value != held_tag_q) begin
					held_tag_q <= frame_value;
				end
				elapsed_q    <= 32'd0;
				in_frame_q   <= 1'b0;
				char_count_q <= '0;
				hex_accum_q  <= 64'd0;
				stopped_q    <= 1'b0;
				overflow_q   <= 1'b0;
			end else if (char_count_q >= MAX_CNT) begin
				// frame too long: drop it
				in_frame_q   <= 1'b0;
				char_count_q <= '0;
				hex_accum_q  <= 64'd0;
				stopped_q    <= 1'b0;
				overflow_q   <= 1'b0;
			end else begin
				char_count_q <= char_count_q + CW'(1);
				if (!stopped_q) begin
					if (item.kind != KIND_HEX) begin
						stopped_q <= 1'b1;
					end else if (!overflow_q) begin
						if (hex_accum_q[63:60] != 4'd0) begin
							overflow_q <= 1'b1;
						end else begin
							hex_accum_q <= {hex_accum_q[59:0], item.digit};
						end
					end
				end
			end
		end
	end

	logic [$bits(result_t)-1:0] res_dout;
	result_t                    res_out;

	rfhft_fifo #(
		.W($bits(result_t))
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_dout),
		.empty (empty)
	);

	assign res_out    = result_t'(res_dout);
	assign event_res  = res_out.event_res;
	assign tag_serial = res_out.tag_serial;

endmodule

FILE: design/rfid_hex_frame_tag_tracker.sv
// Tag reader frame tracker.
// Input queue side: command (0 = UART byte in rx_byte, 1 = one time tick) is
// transferred on a clock edge with push high and full low.
// Result queue side: while empty is low, event_res (0 = new tag, 1 = tag lost)
// and tag_serial show the oldest result; a transfer happens on pop with empty low.
// Config: cfg_wr_en writes lost_timeout from cfg_wr_data.
// Throughput: one item per cycle while the result queue is not full. The front
// classifies each item into a two-entry queue; the back updates frame and tag
// state, one item per cycle, and feeds a two-entry result queue.
// An item waits in the input queue; its result is then held in the result queue.
// At most one result per item; most items give none.
// Reset: both queues empty, no frame open, no tag held, elapsed count zero,
// lost_timeout = 200000.
// When the receiver stalls, the result queue fills, the back stops, the input
// queue fills and full rises; nothing is dropped.
module rfid_hex_frame_tag_tracker #(
	parameter int unsigned MAX_FRAME_CHARS = rfhft_pkg::FRAME_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        event_res,
	output logic [63:0] tag_serial,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import rfhft_pkg::*;

	item_t item;
	logic  item_empty;
	logic  item_take;

	rfhft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.rx_byte   (rx_byte),
		.item_take (item_take),
		.item      (item),
		.item_empty(item_empty)
	);

	rfhft_back #(
		.MAX_FRAME_CHARS(MAX_FRAME_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item),
		.item_empty (item_empty),
		.item_take  (item_take),
		.empty      (empty),
		.pop        (pop),
		.event_res  (event_res),
		.tag_serial (tag_serial)
	);

endmodule

FILE: design/rfhft_checker.sv
module rfhft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic        event_res,
	input logic [63:0] tag_serial
);
	import rfhft_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result queue not empty after reset");

	a_reset_not_full: assert property (@(posedge clk) !arst_n |=> !full)
		else $error("input queue full after reset");

	a_lost_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_res == EVENT_LOST) |-> tag_serial != 64'd0)
		else $error("lost event for tag zero");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_res) && $stable(tag_serial)))
		else $error("waiting result changed");

endmodule

bind rfid_hex_frame_tag_tracker rfhft_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.event_res  (event_res),
	.tag_serial (tag_serial)
);
